### design/rcc_pkg.sv
// Shared constants, types and the direction table of the ray-circle caster.
package rcc_pkg;

    localparam int NUM_RAYS = 360;
    localparam int QUARTER  = NUM_RAYS / 4;

    localparam int IDX_W     = 9;
    localparam int KQ_W      = $clog2(QUARTER);
    localparam int COORD_W   = 10;
    localparam int RAD_W     = 9;
    localparam int LEN_W     = 11;
    localparam int END_W     = 12;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;

    localparam int DIR_W   = 16;
    localparam int ENTRY_W = 2 * DIR_W;
    localparam int OFS_W   = COORD_W + 1;
    localparam int H_W     = 28;
    localparam int A_W     = 32;
    localparam int C_W     = 23;
    localparam int D_W     = 56;
    localparam int S_W     = D_W / 2;
    localparam int N_W     = 27;
    localparam int FRAC_T  = 25;
    localparam int NUM_W   = N_W + FRAC_T;
    localparam int T_W     = 24;
    localparam int M_W     = T_W + 1;
    localparam int LEN_SHIFT = FRAC_T - 15;
    localparam int P_W     = 42;
    localparam int SUM_W   = P_W + 1;

    localparam logic [COORD_W-1:0] CX_RESET  = 10'd400;
    localparam logic [COORD_W-1:0] CY_RESET  = 10'd300;
    localparam logic [RAD_W-1:0]   RAD_RESET = 9'd50;
    localparam logic [LEN_W-1:0]   LEN_RESET = 11'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X,
        REG_CENTER_Y,
        REG_RADIUS,
        REG_RAY_LENGTH
    } cfg_reg_t;

    typedef struct packed {
        logic [COORD_W-1:0]      lx;
        logic [COORD_W-1:0]      ly;
        logic signed [DIR_W-1:0] dx;
        logic signed [DIR_W-1:0] dy;
    } pass_t;

    typedef struct packed {
        pass_t                 p;
        logic signed [H_W-1:0] h;
        logic [A_W-1:0]        a;
        logic                  dneg;
    } sq_side_t;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint          ONE_Q30     = 64'd1073741824;

    // Long division by shift and subtract; used only while building the table.
    function automatic longint unsigned udiv_const(longint unsigned num,
                                                   longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int bi = 63; bi >= 0; bi--)
        begin
            r = (r << 1) | ((num >> bi) & 64'd1);
            if (r >= den)
            begin
                r = r - den;
                q = q | (64'd1 << bi);
            end
        end
        return q;
    endfunction

    // Entry k holds {sin, cos} in Q1.15 for angle step k of the first quadrant.
    function automatic logic [QUARTER*ENTRY_W-1:0] build_dir_table();
        logic [QUARTER*ENTRY_W-1:0] tbl;
        longint unsigned phase;
        longint unsigned th;
        longint unsigned th2;
        longint unsigned term;
        longint          s;
        longint          c;
        longint          sq;
        longint          cq;
        tbl = '0;
        for (int k = 0; k < QUARTER; k++)
        begin
            phase = udiv_const(longint'(k) << 32, longint'(NUM_RAYS));
            th    = ((phase & 64'h3FFF_FFFF) * HALF_PI_Q30) >> 30;
            th2   = (th * th) >> 30;
            term  = th;
            s     = longint'(th);
            for (int j = 1; j <= 7; j++)
            begin
                term = udiv_const((term * th2) >> 30, longint'((2 * j) * (2 * j + 1)));
                if (j[0])
                    s = s - longint'(term);
                else
                    s = s + longint'(term);
            end
            term = ONE_Q30;
            c    = ONE_Q30;
            for (int j = 1; j <= 7; j++)
            begin
                term = udiv_const((term * th2) >> 30, longint'((2 * j - 1) * (2 * j)));
                if (j[0])
                    c = c - longint'(term);
                else
                    c = c + longint'(term);
            end
            if (s < 0) s = 0;
            if (s > ONE_Q30) s = ONE_Q30;
            if (c < 0) c = 0;
            if (c > ONE_Q30) c = ONE_Q30;
            sq = (s + 16384) >>> 15;
            cq = (c + 16384) >>> 15;
            if (sq > 32767) sq = 32767;
            if (cq > 32767) cq = 32767;
            tbl[k*ENTRY_W +: ENTRY_W] = {sq[DIR_W-1:0], cq[DIR_W-1:0]};
        end
        return tbl;
    endfunction

    localparam logic [QUARTER*ENTRY_W-1:0] DIR_TABLE = build_dir_table();

endpackage

### design/rcc_isqrt.sv
// Pipelined integer square root, two result bits per stage.
module rcc_isqrt import rcc_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  logic [D_W-1:0] radicand,
    input  sq_side_t       in_side,
    output logic           out_valid,
    output logic [S_W-1:0] root,
    output sq_side_t       out_side
);

    localparam int STEPS  = 2;
    localparam int STAGES = S_W / STEPS;

    logic           v_reg    [STAGES];
    logic [D_W-1:0] rem_reg  [STAGES];
    logic [D_W-1:0] res_reg  [STAGES];
    sq_side_t       side_reg [STAGES];

    genvar g;
    for (g = 0; g < STAGES; g++)
    begin : g_stage
        logic           v_in;
        logic [D_W-1:0] rem_in;
        logic [D_W-1:0] res_in;
        sq_side_t       side_in;
        logic [D_W-1:0] rem_next;
        logic [D_W-1:0] res_next;

        if (g == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = radicand;
            assign res_in  = '0;
            assign side_in = in_side;
        end
        else
        begin : g_rest
            assign v_in    = v_reg[g-1];
            assign rem_in  = rem_reg[g-1];
            assign res_in  = res_reg[g-1];
            assign side_in = side_reg[g-1];
        end

        always_comb
        begin : p_step
            logic [D_W-1:0] rem;
            logic [D_W-1:0] res;
            logic [D_W-1:0] bitv;
            rem = rem_in;
            res = res_in;
            for (int j = 0; j < STEPS; j++)
            begin
                bitv = D_W'(1) << (D_W - 2 - 2 * (STEPS * g + j));
                if (rem >= res + bitv)
                begin
                    rem = rem - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                begin
                    res = res >> 1;
                end
            end
            rem_next = rem;
            res_next = res;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[g] <= 1'b0;
            else if (en)
                v_reg[g] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g]  <= rem_next;
                res_reg[g]  <= res_next;
                side_reg[g] <= side_in;
            end
        end
    end

    assign out_valid = v_reg[STAGES-1];
    assign root      = res_reg[STAGES-1][S_W-1:0];
    assign out_side  = side_reg[STAGES-1];

endmodule

### design/rcc_div.sv
// Pipelined unsigned restoring divider, two quotient bits per stage.
module rcc_div import rcc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] num,
    input  logic [A_W-1:0]   den,
    input  pass_t            in_side,
    output logic             out_valid,
    output logic [T_W-1:0]   quot,
    output pass_t            out_side
);

    localparam int STEPS  = 2;
    localparam int STAGES = T_W / STEPS;

    logic           v_reg    [STAGES];
    logic [A_W-1:0] rem_reg  [STAGES];
    logic [A_W-1:0] den_reg  [STAGES];
    logic [T_W-1:0] lo_reg   [STAGES];
    logic [T_W-1:0] q_reg    [STAGES];
    pass_t          side_reg [STAGES];

    genvar g;
    for (g = 0; g < STAGES; g++)
    begin : g_stage
        logic           v_in;
        logic [A_W-1:0] rem_in;
        logic [A_W-1:0] den_in;
        logic [T_W-1:0] lo_in;
        logic [T_W-1:0] q_in;
        pass_t          side_in;
        logic [A_W-1:0] rem_next;
        logic [T_W-1:0] lo_next;
        logic [T_W-1:0] q_next;

        if (g == 0)
        begin : g_first
            // High dividend bits stay below the divisor, so the quotient fits T_W bits.
            assign v_in    = in_valid;
            assign rem_in  = A_W'(num[NUM_W-1:T_W]);
            assign den_in  = den;
            assign lo_in   = num[T_W-1:0];
            assign q_in    = '0;
            assign side_in = in_side;
        end
        else
        begin : g_rest
            assign v_in    = v_reg[g-1];
            assign rem_in  = rem_reg[g-1];
            assign den_in  = den_reg[g-1];
            assign lo_in   = lo_reg[g-1];
            assign q_in    = q_reg[g-1];
            assign side_in = side_reg[g-1];
        end

        always_comb
        begin : p_step
            logic [A_W:0]   trial;
            logic [A_W-1:0] rem;
            logic [T_W-1:0] lo;
            logic [T_W-1:0] q;
            rem = rem_in;
            lo  = lo_in;
            q   = q_in;
            for (int j = 0; j < STEPS; j++)
            begin
                trial = {rem, lo[T_W-1]};
                lo    = lo << 1;
                if (trial >= {1'b0, den_in})
                begin
                    rem = A_W'(trial - {1'b0, den_in});
                    q   = {q[T_W-2:0], 1'b1};
                end
                else
                begin
                    rem = trial[A_W-1:0];
                    q   = {q[T_W-2:0], 1'b0};
                end
            end
            rem_next = rem;
            lo_next  = lo;
            q_next   = q;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[g] <= 1'b0;
            else if (en)
                v_reg[g] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g]  <= rem_next;
                den_reg[g]  <= den_in;
                lo_reg[g]   <= lo_next;
                q_reg[g]    <= q_next;
                side_reg[g] <= side_in;
            end
        end
    end

    assign out_valid = v_reg[STAGES-1];
    assign quot      = q_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];

endmodule

### design/ray_circle_caster.sv
// Ray caster top level: direction lookup, quadratic setup, root and end point.
// Each item passes through 38 register stages, the first loaded on accept.
// Throughput: one item per cycle; the whole pipeline advances together and
// holds while the output register is full and not taken.
// Reset clears all valid bits and loads the register defaults
// (center 400/300, radius 50, ray length 1000).
module ray_circle_caster import rcc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [COORD_W-1:0]    light_x,
    input  logic [COORD_W-1:0]    light_y,
    input  logic [IDX_W-1:0]      ray_index,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [END_W-1:0] end_x,
    output logic signed [END_W-1:0] end_y,
    output logic                  hit
);

    localparam int WHOLE_W    = SUM_W - FRAC_T;
    localparam int TRUNC_BIAS = (1 << FRAC_T) - 1;
    localparam int END_MAX    = (1 << (END_W - 1)) - 1;
    localparam int END_MIN    = -(1 << (END_W - 1));

    typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_t;

    logic [COORD_W-1:0] center_x_reg;
    logic [COORD_W-1:0] center_y_reg;
    logic [RAD_W-1:0]   radius_reg;
    logic [LEN_W-1:0]   ray_length_reg;

    logic adv;

    logic va_reg, vb_reg, vc_reg, vd_reg, ve_reg, vf_reg, vg_reg;
    logic vh_reg, vi_reg, vj_reg, vk_reg, out_valid_reg;

    logic [COORD_W-1:0] a_lx_reg, a_ly_reg;
    logic [IDX_W-1:0]   a_idx_reg;

    logic [IDX_W-1:0]   k_mod;
    quad_t              b_quad_next, b_quad_reg;
    logic [KQ_W-1:0]    b_k_next, b_k_reg;
    logic [COORD_W-1:0] b_lx_reg, b_ly_reg;

    logic [ENTRY_W-1:0]      entry;
    logic signed [DIR_W-1:0] sin_q, cos_q, c_dx_next, c_dy_next;
    logic signed [DIR_W-1:0] c_dx_reg, c_dy_reg;
    logic signed [OFS_W-1:0] c_ox_reg, c_oy_reg;
    logic [COORD_W-1:0]      c_lx_reg, c_ly_reg;

    logic signed [DIR_W+OFS_W-1:0] d_oxdx_reg, d_oydy_reg;
    logic signed [A_W-1:0]         d_dxdx_reg, d_dydy_reg;
    logic signed [2*OFS_W-1:0]     d_oxox_reg, d_oyoy_reg;
    logic [2*RAD_W-1:0]            d_rr_reg;
    pass_t                         d_p_reg;

    logic signed [H_W-1:0] e_h_reg;
    logic [A_W-1:0]        e_a_reg;
    logic signed [C_W-1:0] e_c_reg;
    pass_t                 e_p_reg;

    logic signed [D_W-1:0] f_hh_reg, f_ac_reg;
    logic signed [H_W-1:0] f_h_reg;
    logic [A_W-1:0]        f_a_reg;
    pass_t                 f_p_reg;

    logic signed [D_W-1:0] g_d_reg;
    logic signed [H_W-1:0] g_h_reg;
    logic [A_W-1:0]        g_a_reg;
    pass_t                 g_p_reg;

    logic [D_W-1:0] sq_in;
    sq_side_t       sq_side_in, sq_side_out;
    logic           sq_valid;
    logic [S_W-1:0] sq_root;

    logic signed [H_W+1:0] n_val;
    logic                  pos;
    logic [N_W-1:0]        h_num_reg;
    logic [A_W-1:0]        h_a_reg;
    pass_t                 h_p_reg;

    logic           dv_valid;
    logic [T_W-1:0] dv_quot;
    pass_t          dv_side;

    logic           i_hit_next, i_hit_reg;
    logic [M_W-1:0] i_m_next, i_m_reg;
    pass_t          i_p_reg;

    logic signed [P_W-1:0] j_px_reg, j_py_reg;
    logic [COORD_W-1:0]    j_lx_reg, j_ly_reg;
    logic                  j_hit_reg;

    logic signed [SUM_W-1:0] k_sx_reg, k_sy_reg;
    logic                    k_hit_reg;

    logic signed [END_W-1:0] end_x_reg, end_y_reg;
    logic                    hit_reg;

    function automatic logic signed [END_W-1:0] to_end(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0]   biased;
        logic signed [WHOLE_W-1:0] whole;
        biased = v[SUM_W-1] ? v + SUM_W'(TRUNC_BIAS) : v;
        whole  = WHOLE_W'(biased >>> FRAC_T);
        if (whole > WHOLE_W'(END_MAX))
            return END_W'(END_MAX);
        else if (whole < WHOLE_W'(END_MIN))
            return END_W'(END_MIN);
        else
            return END_W'(whole);
    endfunction

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg   <= CX_RESET;
            center_y_reg   <= CY_RESET;
            radius_reg     <= RAD_RESET;
            ray_length_reg <= LEN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CENTER_X:   center_x_reg   <= cfg_data[COORD_W-1:0];
                REG_CENTER_Y:   center_y_reg   <= cfg_data[COORD_W-1:0];
                REG_RADIUS:     radius_reg     <= cfg_data[RAD_W-1:0];
                REG_RAY_LENGTH: ray_length_reg <= cfg_data[LEN_W-1:0];
                default:        ;
            endcase
        end
    end

    // Advance all stages unless the output item is held
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // Angle step: wrap the index, then split into quadrant and offset
    always_comb
    begin
        k_mod = (a_idx_reg >= IDX_W'(NUM_RAYS)) ? a_idx_reg - IDX_W'(NUM_RAYS) : a_idx_reg;
        if (k_mod < IDX_W'(QUARTER))
        begin
            b_quad_next = QUAD_0;
            b_k_next    = KQ_W'(k_mod);
        end
        else if (k_mod < IDX_W'(2 * QUARTER))
        begin
            b_quad_next = QUAD_1;
            b_k_next    = KQ_W'(k_mod - IDX_W'(QUARTER));
        end
        else if (k_mod < IDX_W'(3 * QUARTER))
        begin
            b_quad_next = QUAD_2;
            b_k_next    = KQ_W'(k_mod - IDX_W'(2 * QUARTER));
        end
        else
        begin
            b_quad_next = QUAD_3;
            b_k_next    = KQ_W'(k_mod - IDX_W'(3 * QUARTER));
        end
    end

    // Direction from the quarter table with quadrant signs
    always_comb
    begin
        entry = DIR_TABLE[b_k_reg * ENTRY_W +: ENTRY_W];
        sin_q = $signed(entry[ENTRY_W-1:DIR_W]);
        cos_q = $signed(entry[DIR_W-1:0]);
        case (b_quad_reg)
            QUAD_0:
            begin
                c_dx_next = cos_q;
                c_dy_next = sin_q;
            end
            QUAD_1:
            begin
                c_dx_next = -sin_q;
                c_dy_next = cos_q;
            end
            QUAD_2:
            begin
                c_dx_next = -cos_q;
                c_dy_next = -sin_q;
            end
            default:
            begin
                c_dx_next = sin_q;
                c_dy_next = -cos_q;
            end
        endcase
    end

    assign sq_in      = g_d_reg[D_W-1] ? '0 : g_d_reg;
    assign sq_side_in = '{p: g_p_reg, h: g_h_reg, a: g_a_reg, dneg: g_d_reg[D_W-1]};

    rcc_isqrt u_isqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (vg_reg),
        .radicand  (sq_in),
        .in_side   (sq_side_in),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_side  (sq_side_out)
    );

    // Nearer root numerator; only a positive one can give a hit
    always_comb
    begin
        n_val = -(H_W+2)'(sq_side_out.h) - (H_W+2)'($signed({1'b0, sq_root}));
        pos   = !sq_side_out.dneg && (n_val > 0);
    end

    rcc_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (vh_reg),
        .num       ({h_num_reg, {FRAC_T{1'b0}}}),
        .den       (h_a_reg),
        .in_side   (h_p_reg),
        .out_valid (dv_valid),
        .quot      (dv_quot),
        .out_side  (dv_side)
    );

    // A miss scales ray_length into the same Q.10 frame as t
    always_comb
    begin
        i_hit_next = (dv_quot > T_W'(1));
        i_m_next   = i_hit_next ? M_W'(dv_quot) : (M_W'(ray_length_reg) << LEN_SHIFT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg        <= 1'b0;
            vb_reg        <= 1'b0;
            vc_reg        <= 1'b0;
            vd_reg        <= 1'b0;
            ve_reg        <= 1'b0;
            vf_reg        <= 1'b0;
            vg_reg        <= 1'b0;
            vh_reg        <= 1'b0;
            vi_reg        <= 1'b0;
            vj_reg        <= 1'b0;
            vk_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg        <= in_valid;
            vb_reg        <= va_reg;
            vc_reg        <= vb_reg;
            vd_reg        <= vc_reg;
            ve_reg        <= vd_reg;
            vf_reg        <= ve_reg;
            vg_reg        <= vf_reg;
            vh_reg        <= sq_valid;
            vi_reg        <= dv_valid;
            vj_reg        <= vi_reg;
            vk_reg        <= vj_reg;
            out_valid_reg <= vk_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_lx_reg  <= light_x;
            a_ly_reg  <= light_y;
            a_idx_reg <= ray_index;

            b_quad_reg <= b_quad_next;
            b_k_reg    <= b_k_next;
            b_lx_reg   <= a_lx_reg;
            b_ly_reg   <= a_ly_reg;

            c_dx_reg <= c_dx_next;
            c_dy_reg <= c_dy_next;
            c_ox_reg <= $signed({1'b0, b_lx_reg}) - $signed({1'b0, center_x_reg});
            c_oy_reg <= $signed({1'b0, b_ly_reg}) - $signed({1'b0, center_y_reg});
            c_lx_reg <= b_lx_reg;
            c_ly_reg <= b_ly_reg;

            d_oxdx_reg <= c_ox_reg * c_dx_reg;
            d_oydy_reg <= c_oy_reg * c_dy_reg;
            d_dxdx_reg <= c_dx_reg * c_dx_reg;
            d_dydy_reg <= c_dy_reg * c_dy_reg;
            d_oxox_reg <= c_ox_reg * c_ox_reg;
            d_oyoy_reg <= c_oy_reg * c_oy_reg;
            d_rr_reg   <= radius_reg * radius_reg;
            d_p_reg    <= '{lx: c_lx_reg, ly: c_ly_reg, dx: c_dx_reg, dy: c_dy_reg};

            e_h_reg <= H_W'(d_oxdx_reg) + H_W'(d_oydy_reg);
            e_a_reg <= A_W'(d_dxdx_reg) + A_W'(d_dydy_reg);
            e_c_reg <= C_W'(d_oxox_reg) + C_W'(d_oyoy_reg) - C_W'(d_rr_reg);
            e_p_reg <= d_p_reg;

            f_hh_reg <= e_h_reg * e_h_reg;
            f_ac_reg <= $signed({1'b0, e_a_reg}) * e_c_reg;
            f_h_reg  <= e_h_reg;
            f_a_reg  <= e_a_reg;
            f_p_reg  <= e_p_reg;

            g_d_reg <= f_hh_reg - f_ac_reg;
            g_h_reg <= f_h_reg;
            g_a_reg <= f_a_reg;
            g_p_reg <= f_p_reg;

            h_num_reg <= pos ? N_W'(n_val) : '0;
            h_a_reg   <= sq_side_out.a;
            h_p_reg   <= sq_side_out.p;

            i_hit_reg <= i_hit_next;
            i_m_reg   <= i_m_next;
            i_p_reg   <= dv_side;

            j_px_reg  <= $signed(i_p_reg.dx) * $signed({1'b0, i_m_reg});
            j_py_reg  <= $signed(i_p_reg.dy) * $signed({1'b0, i_m_reg});
            j_lx_reg  <= i_p_reg.lx;
            j_ly_reg  <= i_p_reg.ly;
            j_hit_reg <= i_hit_reg;

            k_sx_reg  <= SUM_W'($signed({1'b0, j_lx_reg, {FRAC_T{1'b0}}})) + SUM_W'(j_px_reg);
            k_sy_reg  <= SUM_W'($signed({1'b0, j_ly_reg, {FRAC_T{1'b0}}})) + SUM_W'(j_py_reg);
            k_hit_reg <= j_hit_reg;

            end_x_reg <= to_end(k_sx_reg);
            end_y_reg <= to_end(k_sy_reg);
            hit_reg   <= k_hit_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign end_x     = end_x_reg;
    assign end_y     = end_y_reg;
    assign hit       = hit_reg;

endmodule

### bench/ray_circle_caster_test.sv
// Self-checking bench for the ray-circle caster: directed rays, then random rays.
`timescale 1ns / 100ps

module ray_circle_caster_test;
    import rcc_pkg::*;

    typedef struct {
        logic signed [END_W-1:0] end_x;
        logic signed [END_W-1:0] end_y;
        logic                    hit;
    } ray_end_t;

    typedef struct {
        int unsigned             lx;
        int unsigned             ly;
        int unsigned             idx;
        bit                      typed;
        logic signed [END_W-1:0] ex;
        logic signed [END_W-1:0] ey;
        logic                    eh;
    } ray_row_t;

    localparam int SET_COUNT    = 5;
    localparam int RAYS_PER_SET = 126;
    localparam int LATENCY      = 38;
    localparam int CYCLE_LIMIT  = 200000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic [COORD_W-1:0] light_x;
    logic [COORD_W-1:0] light_y;
    logic [IDX_W-1:0] ray_index;
    logic out_valid;
    logic out_ready;
    logic signed [END_W-1:0] end_x;
    logic signed [END_W-1:0] end_y;
    logic hit;

    ray_circle_caster dut (.*);

    // Circle setup as the predictor sees it.
    longint circ_cx;
    longint circ_cy;
    longint circ_r;
    longint miss_len;

    ray_end_t pending_ends[$];
    int unsigned mismatches;
    int unsigned cycles;
    bit calm;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [END_W-1:0] clamp_end(longint v);
        if (v > 2047)
            v = 2047;
        if (v < -2048)
            v = -2048;
        return v[END_W-1:0];
    endfunction

    function automatic ray_end_t cast_ray(longint lx, longint ly, longint unsigned idx);
        ray_end_t r;
        longint unsigned k;
        longint unsigned phase;
        longint unsigned th;
        longint unsigned th2;
        longint unsigned term;
        longint sn;
        longint cs;
        longint dx;
        longint dy;
        longint ox;
        longint oy;
        longint h;
        longint a;
        longint c;
        longint d;
        longint s;
        longint t;
        longint ex;
        longint ey;
        bit is_hit;
        k = idx % NUM_RAYS;
        phase = (k << 32) / NUM_RAYS;
        th = ((phase & 64'h3FFF_FFFF) * 64'd1686629713) >> 30;
        th2 = (th * th) >> 30;
        // Taylor series for sine and cosine of the in-quadrant angle, Q30
        term = th;
        sn = th;
        for (int j = 1; j <= 7; j++)
        begin
            term = ((term * th2) >> 30) / ((2 * j) * (2 * j + 1));
            if (j % 2 == 1)
                sn = sn - longint'(term);
            else
                sn = sn + longint'(term);
        end
        term = 64'd1 << 30;
        cs = 64'd1 << 30;
        for (int j = 1; j <= 7; j++)
        begin
            term = ((term * th2) >> 30) / ((2 * j - 1) * (2 * j));
            if (j % 2 == 1)
                cs = cs - longint'(term);
            else
                cs = cs + longint'(term);
        end
        if (sn < 0) sn = 0;
        if (sn > (64'sd1 << 30)) sn = 64'sd1 << 30;
        if (cs < 0) cs = 0;
        if (cs > (64'sd1 << 30)) cs = 64'sd1 << 30;
        sn = (sn + 16384) >>> 15;
        cs = (cs + 16384) >>> 15;
        if (sn > 32767) sn = 32767;
        if (cs > 32767) cs = 32767;
        case ((phase >> 30) & 3)
            0: begin dx = cs;  dy = sn;  end
            1: begin dx = -sn; dy = cs;  end
            2: begin dx = -cs; dy = -sn; end
            default: begin dx = sn; dy = -cs; end
        endcase
        ox = lx - circ_cx;
        oy = ly - circ_cy;
        h = ox * dx + oy * dy;
        a = dx * dx + dy * dy;
        c = ox * ox + oy * oy - circ_r * circ_r;
        d = h * h - a * c;
        is_hit = 1'b0;
        t = 0;
        if (d >= 0 && a > 0)
        begin
            s = int_sqrt(d);
            t = ((-h - s) * 64'sd33554432) / a;
            is_hit = t > 1;
        end
        if (is_hit)
        begin
            ex = (lx * 64'sd33554432 + dx * t) / 64'sd33554432;
            ey = (ly * 64'sd33554432 + dy * t) / 64'sd33554432;
        end
        else
        begin
            ex = (lx * 64'sd32768 + dx * miss_len) / 64'sd32768;
            ey = (ly * 64'sd32768 + dy * miss_len) / 64'sd32768;
        end
        r.end_x = clamp_end(ex);
        r.end_y = clamp_end(ey);
        r.hit = is_hit;
        return r;
    endfunction

    // Drive one item; push its expected end once acceptance is certain.
    task automatic send_ray(ray_row_t row);
        ray_end_t e;
        light_x <= row.lx[COORD_W-1:0];
        light_y <= row.ly[COORD_W-1:0];
        ray_index <= row.idx[IDX_W-1:0];
        in_valid <= 1'b1;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        if (row.typed)
        begin
            e.end_x = row.ex;
            e.end_y = row.ey;
            e.hit = row.eh;
        end
        else
            e = cast_ray(row.lx, row.ly, row.idx);
        pending_ends.push_back(e);
        @(posedge clk);
        if (!calm && $urandom_range(99) < 16)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(4, 1))
                @(posedge clk);
        end
    endtask

    task automatic write_reg(cfg_reg_t r, int unsigned v);
        cfg_we <= 1'b1;
        cfg_index <= r;
        cfg_data <= v[CFG_W-1:0];
        case (r)
            REG_CENTER_X: circ_cx = v;
            REG_CENTER_Y: circ_cy = v;
            REG_RADIUS: circ_r = v;
            default: miss_len = v;
        endcase
        @(posedge clk);
    endtask

    task automatic load_circle(int unsigned cx, int unsigned cy, int unsigned r,
                               int unsigned len);
        in_valid <= 1'b0;
        while (pending_ends.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4)
            @(posedge clk);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_RADIUS, r);
        write_reg(REG_RAY_LENGTH, len);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic int unsigned near_coord(longint ctr);
        longint v;
        v = ctr + longint'($urandom_range(2 * circ_r + 128)) - circ_r - 64;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        return v;
    endfunction

    ray_row_t directed[] = '{
        '{0, 0, 0, 1, 999, 0, 0},
        '{400, 300, 0, 1, 1399, 300, 0},
        '{400, 300, 90, 1, 400, 1299, 0},
        '{0, 0, 180, 1, -999, 0, 0},
        '{1023, 1023, 270, 1, 1023, 23, 0},
        '{0, 300, 0, 0, 0, 0, 0},
        '{300, 300, 0, 0, 0, 0, 0},
        '{1023, 300, 180, 0, 0, 0, 0},
        '{400, 0, 90, 0, 0, 0, 0},
        '{400, 400, 270, 0, 0, 0, 0},
        '{350, 300, 0, 0, 0, 0, 0},
        '{400, 250, 90, 0, 0, 0, 0},
        '{450, 300, 0, 0, 0, 0, 0},
        '{0, 350, 0, 0, 0, 0, 0},
        '{0, 351, 0, 0, 0, 0, 0},
        '{0, 0, 37, 0, 0, 0, 0},
        '{1023, 1023, 359, 0, 0, 0, 0},
        '{511, 511, 360, 0, 0, 0, 0},
        '{0, 1023, 511, 0, 0, 0, 0},
        '{682, 341, 45, 0, 0, 0, 0},
        '{400, 349, 90, 0, 0, 0, 0},
        '{399, 300, 180, 0, 0, 0, 0},
        '{200, 100, 45, 0, 0, 0, 0}
    };

    int unsigned set_cx[SET_COUNT] = '{0, 1023, 512, 100, 400};
    int unsigned set_cy[SET_COUNT] = '{0, 1023, 512, 900, 300};
    int unsigned set_r[SET_COUNT] = '{0, 511, 511, 200, 50};
    int unsigned set_len[SET_COUNT] = '{0, 2047, 2047, 1, 1000};

    always @(posedge clk)
        out_ready <= calm || ($urandom_range(99) >= 16);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Compare each item taken from the output; acceptance follows at the next edge.
    always @(negedge clk)
    begin
        ray_end_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_ends.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: end %0d,%0d hit %0b", end_x, end_y, hit);
            end
            else
            begin
                e = pending_ends.pop_front();
                if (e.end_x !== end_x || e.end_y !== end_y || e.hit !== hit)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d,%0d hit %0b, got %0d,%0d hit %0b",
                                 e.end_x, e.end_y, e.hit, end_x, end_y, hit);
                end
            end
        end
    end

    initial
    begin
        ray_row_t row;
        int unsigned sent;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_CENTER_X;
        cfg_data = '0;
        in_valid = 1'b0;
        light_x = '0;
        light_y = '0;
        ray_index = '0;
        out_ready = 1'b0;
        cycles = 0;
        mismatches = 0;
        calm = 1'b0;
        circ_cx = 400;
        circ_cy = 300;
        circ_r = 50;
        miss_len = 1000;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_ray(directed[i]);

        sent = 0;
        for (int p = 0; p < SET_COUNT; p++)
        begin
            load_circle(set_cx[p], set_cy[p], set_r[p], set_len[p]);
            for (int n = 0; n < RAYS_PER_SET; n++)
            begin
                // hold off idling on both sides for one long stretch
                calm = (sent >= 300 && sent < 400);
                row.typed = 1'b0;
                if ($urandom_range(99) < 70)
                begin
                    row.lx = near_coord(circ_cx);
                    row.ly = near_coord(circ_cy);
                end
                else
                begin
                    row.lx = $urandom_range(1023);
                    row.ly = $urandom_range(1023);
                end
                if ($urandom_range(9) == 0)
                    row.idx = $urandom_range(511, 360);
                else
                    row.idx = $urandom_range(359);
                send_ray(row);
                sent++;
            end
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (pending_ends.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10)
            @(posedge clk);
        if (mismatches == 0 && pending_ends.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
